/* sv/fuzzy_distance_defuzzifier_assert.svh */
// ---------------------------------------------------------------------------
// Fuzzy distance defuzzifier assertion macros
// Shared concurrent assertion forms for the defuzzifier RTL.
// ---------------------------------------------------------------------------
`ifndef FUZZY_DISTANCE_DEFUZZIFIER_ASSERT_SVH
`define FUZZY_DISTANCE_DEFUZZIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FDD_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FDD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fdd_pkg.sv */
// ---------------------------------------------------------------------------
// Fuzzy distance defuzzifier package
// Default parameters and configuration register indexes.
// ---------------------------------------------------------------------------
package fdd_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  // Configuration register index width
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BREAK_LOW     = 3'd0,
    REG_BREAK_MID     = 3'd1,
    REG_BREAK_HIGH    = 3'd2,
    REG_WEIGHT_NEAR   = 3'd3,
    REG_WEIGHT_MIDDLE = 3'd4,
    REG_WEIGHT_FAR    = 3'd5,
    REG_LEVEL_FULL    = 3'd6,
    REG_LEVEL_NONE    = 3'd7
  } cfg_reg_t;

endpackage

/* sv/fuzzy_distance_defuzzifier.sv */
// ---------------------------------------------------------------------------
// Fuzzy distance defuzzifier
// Three-rule zero-order fuzzy inference on a Q distance sample, with a
// pipelined restoring divider producing a saturated signed Q result.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | input     | in_valid / in_ready   | in_distance
//  out_    | output    | out_valid / out_ready | out_control_value,
//          |           |                       | out_divide_by_zero, out_saturated
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while out_ready holds; the divider retires one quotient bit
//  per pipeline stage.
//  Synchronous active-low reset clears valid bits and loads register defaults.
//  A stalled output holds its stage; empty stages ahead of a stall still fill,
//  so in_ready drops only when every stage holds an item.
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
`include "fuzzy_distance_defuzzifier_assert.svh"

module fuzzy_distance_defuzzifier
  import fdd_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [DATA_WIDTH-1:0]        in_distance,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_control_value,
  output logic                         out_divide_by_zero,
  output logic                         out_saturated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_data
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int MW   = W + 1;          // membership, signed
  localparam int PW   = MW + W;         // membership times weight, signed
  localparam int NUMW = PW + 2;         // numerator, signed
  localparam int DENW = MW + 2;         // membership sum, signed
  localparam int DIVW = DENW + W;       // divisor, signed
  localparam int NMW  = NUMW + F;       // scaled numerator magnitude
  localparam int DMW  = DIVW;           // divisor magnitude
  localparam int XW   = (NMW > DMW + W) ? NMW + 1 : DMW + W + 1;  // compare width

  // Stage positions
  localparam int ST_MEMB = 0;
  localparam int ST_MUL  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_ABS  = 3;
  localparam int ST_OVF  = 4;
  localparam int ST_DIV0 = 5;
  localparam int NSTG    = ST_DIV0 + W + 1;
  localparam int ST_OUT  = NSTG - 1;

  localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic        [W-1:0] break_low_r, break_mid_r, break_high_r;
  logic signed [W-1:0] weight_near_r, weight_middle_r, weight_far_r;
  logic signed [W-1:0] level_full_r, level_none_r;

  assign cfg_ready = 1'b1;

  // Load a register on each write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_low_r     <= W'(1 << F);
      break_mid_r     <= W'(2 << F);
      break_high_r    <= W'(3 << F);
      weight_near_r   <= '0;
      weight_middle_r <= W'(1 << F);
      weight_far_r    <= W'(2 << F);
      level_full_r    <= W'(1 << F);
      level_none_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BREAK_LOW:     break_low_r     <= cfg_data;
        REG_BREAK_MID:     break_mid_r     <= cfg_data;
        REG_BREAK_HIGH:    break_high_r    <= cfg_data;
        REG_WEIGHT_NEAR:   weight_near_r   <= cfg_data;
        REG_WEIGHT_MIDDLE: weight_middle_r <= cfg_data;
        REG_WEIGHT_FAR:    weight_far_r    <= cfg_data;
        REG_LEVEL_FULL:    level_full_r    <= cfg_data;
        REG_LEVEL_NONE:    level_none_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Valid bits and per-stage advance
  // -------------------------------------------------------------------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = en[ST_MEMB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[ST_MEMB]) begin
        v_r[ST_MEMB] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stage 0: memberships
  // -------------------------------------------------------------------------
  logic signed [MW-1:0] m_short_nxt, m_med_nxt, m_long_nxt;
  logic signed [MW-1:0] m_short_r, m_med_r, m_long_r;
  logic signed [MW-1:0] d_x, lo_x, mid_x, hi_x, full_x, none_x;

  always_comb begin
    d_x    = $signed({1'b0, in_distance});
    lo_x   = $signed({1'b0, break_low_r});
    mid_x  = $signed({1'b0, break_mid_r});
    hi_x   = $signed({1'b0, break_high_r});
    full_x = MW'(level_full_r);
    none_x = MW'(level_none_r);

    if (in_distance < break_low_r)      m_short_nxt = full_x;
    else if (in_distance < break_mid_r) m_short_nxt = mid_x - d_x;
    else                                m_short_nxt = none_x;

    if (in_distance < break_low_r || in_distance > break_high_r) m_med_nxt = none_x;
    else if (in_distance < break_mid_r) m_med_nxt = d_x - lo_x;
    else                                m_med_nxt = hi_x - d_x;

    if (in_distance < break_mid_r)       m_long_nxt = none_x;
    else if (in_distance < break_high_r) m_long_nxt = d_x - mid_x;
    else                                 m_long_nxt = full_x;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MEMB]) begin
      m_short_r <= m_short_nxt;
      m_med_r   <= m_med_nxt;
      m_long_r  <= m_long_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: rule products and membership sum
  // -------------------------------------------------------------------------
  logic signed [PW-1:0]   p_short_r, p_med_r, p_long_r;
  logic signed [DENW-1:0] den_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      p_short_r <= PW'(m_short_r) * PW'(weight_near_r);
      p_med_r   <= PW'(m_med_r) * PW'(weight_middle_r);
      p_long_r  <= PW'(m_long_r) * PW'(weight_far_r);
      den_r     <= DENW'(m_short_r) + DENW'(m_med_r) + DENW'(m_long_r);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: numerator and divisor
  // -------------------------------------------------------------------------
  logic signed [NUMW-1:0] num_r;
  logic signed [DIVW-1:0] div_r;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      num_r <= NUMW'(p_short_r) + NUMW'(p_med_r) + NUMW'(p_long_r);
      div_r <= DIVW'(den_r) * DIVW'(weight_far_r);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: magnitudes, quotient sign, zero divisor
  // -------------------------------------------------------------------------
  logic [NMW-1:0] nmag_r;
  logic [DMW-1:0] dmag_a_r;
  logic           neg_a_r, dz_a_r;
  logic [NUMW-1:0] num_abs;
  logic [DMW-1:0]  div_abs;

  assign num_abs = num_r[NUMW-1] ? NUMW'(-num_r) : NUMW'(num_r);
  assign div_abs = div_r[DIVW-1] ? DMW'(-div_r) : DMW'(div_r);

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      nmag_r   <= {num_abs, {F{1'b0}}};
      dmag_a_r <= div_abs;
      neg_a_r  <= num_r[NUMW-1] ^ div_r[DIVW-1];
      dz_a_r   <= (div_r == '0);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: overflow check, divider entry
  // -------------------------------------------------------------------------
  logic [NMW-1:0] rem_r  [0:W];
  logic [DMW-1:0] dmag_r [0:W];
  logic [W-1:0]   q_r    [0:W];
  logic           neg_r  [0:W];
  logic           dz_r   [0:W];
  logic           ovf_r  [0:W];

  // Quotient of 2^W or more clamps, unless the divisor is zero
  always_ff @(posedge clk) begin
    if (en[ST_OVF]) begin
      rem_r[0]  <= nmag_r;
      dmag_r[0] <= dmag_a_r;
      q_r[0]    <= '0;
      neg_r[0]  <= neg_a_r;
      dz_r[0]   <= dz_a_r;
      ovf_r[0]  <= XW'(nmag_r) >= (XW'(dmag_a_r) << W);
    end
  end

  // -------------------------------------------------------------------------
  // Divider: one quotient bit per stage, most significant first
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < W; i++) begin : g_div
    logic [XW-1:0]  shd;
    logic           ge;
    logic [NMW-1:0] rem_nxt;
    logic [W-1:0]   q_nxt;

    always_comb begin
      shd     = XW'(dmag_r[i]) << (W - 1 - i);
      ge      = XW'(rem_r[i]) >= shd;
      rem_nxt = ge ? NMW'(XW'(rem_r[i]) - shd) : rem_r[i];
      q_nxt   = q_r[i];
      q_nxt[W-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV0 + i]) begin
        rem_r[i+1]  <= rem_nxt;
        dmag_r[i+1] <= dmag_r[i];
        q_r[i+1]    <= q_nxt;
        neg_r[i+1]  <= neg_r[i];
        dz_r[i+1]   <= dz_r[i];
        ovf_r[i+1]  <= ovf_r[i];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output stage: sign, saturation, zero divisor
  // -------------------------------------------------------------------------
  logic signed [W-1:0] val_nxt, val_r;
  logic                sat_nxt, sat_r, dz_o_r;
  logic [W-1:0]        qmag;
  logic                clamp;

  always_comb begin
    qmag  = q_r[W];
    clamp = ovf_r[W] ||
            (neg_r[W] ? (qmag[W-1] && (|qmag[W-2:0])) : qmag[W-1]);
    if (dz_r[W]) begin
      val_nxt = '0;
      sat_nxt = 1'b0;
    end else if (clamp) begin
      val_nxt = neg_r[W] ? MIN_VAL : MAX_VAL;
      sat_nxt = 1'b1;
    end else begin
      val_nxt = neg_r[W] ? $signed(-qmag) : $signed(qmag);
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      val_r  <= val_nxt;
      sat_r  <= sat_nxt;
      dz_o_r <= dz_r[W];
    end
  end

  assign out_valid          = v_r[ST_OUT];
  assign out_control_value  = val_r;
  assign out_divide_by_zero = dz_o_r;
  assign out_saturated      = sat_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `FDD_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !in_ready, &v_r,
    "input blocked while a pipeline stage is empty")
  `FDD_ASSERT_NEXT(a_stage_holds, clk, rst_n, v_r[ST_SUM] && !en[ST_SUM], v_r[ST_SUM],
    "stalled stage dropped its item")
  `FDD_ASSERT_NOW(a_dz_zero, clk, rst_n, out_valid && out_divide_by_zero,
    out_control_value == '0 && !out_saturated,
    "zero divisor result is not zero or is flagged saturated")
  `FDD_ASSERT_NOW(a_sat_bound, clk, rst_n, out_valid && out_saturated,
    out_control_value == MAX_VAL || out_control_value == MIN_VAL,
    "saturated result is not at a bound")

endmodule
